FILE: hdl/wcs_pkg.sv
package wcs_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int WEIGHT_BITS  = 32;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int TOT_W        = WEIGHT_BITS + IDX_W;
  localparam int RND_W        = 32;
  localparam int OUT_IDX_W    = 6;

  typedef enum logic [1:0] {
    ACT_ADD_WEIGHTED = 2'd0,
    ACT_ADD_FIXED    = 2'd1,
    ACT_SELECT       = 2'd2,
    ACT_REWIND       = 2'd3
  } action_t;

  localparam logic [1:0] LC_PARTICLE     = 2'd1;
  localparam logic [1:0] LC_ANTIPARTICLE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    WOP_NONE,
    WOP_MUL_LO,
    WOP_MUL_HI,
    WOP_ACC
  } wop_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIST_OUT,
    S_MUL_LO,
    S_MUL_HI,
    S_WALK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             add;
    logic             rd;
    logic             adv;
    logic             rewind;
    logic             anti;
    logic [IDX_W-1:0] idx;
  } lst_cmd_t;

  typedef struct packed {
    logic             p_nonempty;
    logic             a_nonempty;
    logic             fixed_mode;
    logic [IDX_W-1:0] rd_idx;
  } lst_stat_t;

endpackage

FILE: hdl/wcs_weight_ram.sv
module wcs_weight_ram
  import wcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   we,
  input  logic [IDX_W-1:0]       waddr,
  input  logic [WEIGHT_BITS-1:0] wdata,
  input  logic [IDX_W-1:0]       raddr,
  output logic [WEIGHT_BITS-1:0] rdata
);

  logic [WEIGHT_BITS-1:0] mem [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/wcs_lists.sv
module wcs_lists
  import wcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lst_cmd_t  cmd,
  output lst_stat_t stat
);

  logic [IDX_W-1:0] plist [MAX_CHANNELS];
  logic [IDX_W-1:0] alist [MAX_CHANNELS];

  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0] acnt_r, acnt_nxt;
  logic [IDX_W-1:0] pcur_r, pcur_nxt;
  logic [IDX_W-1:0] acur_r, acur_nxt;
  logic             fixed_r, fixed_nxt;
  logic [IDX_W-1:0] p_rd_r, a_rd_r;
  logic [IDX_W-1:0] ppos, apos;
  logic [CNT_W-1:0] ppos_inc, apos_inc;

  // a cursor past the end of its list restarts at the head
  assign ppos     = (CNT_W'(pcur_r) >= pcnt_r) ? '0 : pcur_r;
  assign apos     = (CNT_W'(acur_r) >= acnt_r) ? '0 : acur_r;
  assign ppos_inc = CNT_W'(ppos) + CNT_W'(1);
  assign apos_inc = CNT_W'(apos) + CNT_W'(1);

  always_comb begin
    pcnt_nxt  = pcnt_r;
    acnt_nxt  = acnt_r;
    pcur_nxt  = pcur_r;
    acur_nxt  = acur_r;
    fixed_nxt = fixed_r;
    if (cmd.add) begin
      fixed_nxt = 1'b1;
      if (cmd.anti) begin
        acnt_nxt = acnt_r + CNT_W'(1);
      end else begin
        pcnt_nxt = pcnt_r + CNT_W'(1);
      end
    end
    if (cmd.rewind) begin
      pcur_nxt = '0;
      acur_nxt = '0;
    end else if (cmd.adv) begin
      if (cmd.anti) begin
        acur_nxt = (apos_inc >= acnt_r) ? '0 : apos_inc[IDX_W-1:0];
      end else begin
        pcur_nxt = (ppos_inc >= pcnt_r) ? '0 : ppos_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r  <= '0;
      acnt_r  <= '0;
      pcur_r  <= '0;
      acur_r  <= '0;
      fixed_r <= 1'b0;
    end else begin
      pcnt_r  <= pcnt_nxt;
      acnt_r  <= acnt_nxt;
      pcur_r  <= pcur_nxt;
      acur_r  <= acur_nxt;
      fixed_r <= fixed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && !cmd.anti) begin
      plist[pcnt_r[IDX_W-1:0]] <= cmd.idx;
    end
    if (cmd.add && cmd.anti) begin
      alist[acnt_r[IDX_W-1:0]] <= cmd.idx;
    end
    if (cmd.rd) begin
      p_rd_r <= plist[ppos];
      a_rd_r <= alist[apos];
    end
  end

  assign stat.p_nonempty = (pcnt_r != '0);
  assign stat.a_nonempty = (acnt_r != '0);
  assign stat.fixed_mode = fixed_r;
  assign stat.rd_idx     = cmd.anti ? a_rd_r : p_rd_r;

endmodule

FILE: hdl/wcs_walker.sv
module wcs_walker
  import wcs_pkg::*;
(
  input  logic                   clk,
  input  wop_t                   op,
  input  logic [TOT_W-1:0]       total,
  input  logic [RND_W-1:0]       rnd,
  input  logic [WEIGHT_BITS-1:0] wdata,
  output logic                   hit
);

  logic [63:0]      tot_ext;
  logic [31:0]      mul_a;
  logic [63:0]      prod;
  logic [63:0]      prod_r;
  logic [TOT_W-1:0] thr_r;
  logic [TOT_W-1:0] cum_r;
  logic [TOT_W-1:0] cum_nxt;

  // one 32x32 multiplier serves both halves of the total
  assign tot_ext = 64'(total);
  assign mul_a   = (op == WOP_MUL_LO) ? tot_ext[31:0] : tot_ext[63:32];
  assign prod    = 64'(mul_a) * 64'(rnd);
  assign cum_nxt = cum_r + TOT_W'(wdata);
  assign hit     = (cum_nxt > thr_r);

  always_ff @(posedge clk) begin
    case (op)
      WOP_MUL_LO: prod_r <= prod;
      WOP_MUL_HI: begin
        thr_r <= TOT_W'(prod + {32'b0, prod_r[63:32]});
        cum_r <= '0;
      end
      WOP_ACC:    cum_r <= cum_nxt;
      default:    ;
    endcase
  end

endmodule

FILE: hdl/weighted_channel_selector.sv
// weighted channel table with roulette-wheel select
// in channel: one item per command, action and list_choice on in_tuser,
//   weight and random_fraction on in_tdata
// out channel: exactly one result item per input item, in order
// each item ends when its result is loaded into the output register; the
//   next item can be taken in the cycle after that
// an add, a rewind or a lone-channel select goes straight to the output state
// a fixed-list select does one registered list read, then takes the list entry as its result
// a weighted select makes two passes through the shared 32x32 multiplier to
//   build the threshold, then the weight memory is read one entry per cycle
//   into the accumulate/compare unit up to the first channel whose running sum
//   passes the threshold, or past the last channel with no channel chosen
// in_tready is high only while the block is idle; one item is worked at a time
// the result is held in a register stage, so a stalled receiver only holds
//   the next result back; the following item is already taken in meanwhile
// reset empties the table, the fixed lists and their cursors and clears
//   fixed mode; the stored weights and list entries are not cleared
module weighted_channel_selector
  import wcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // weight[31:0], random_fraction[63:32]
  input  logic [3:0]  in_tuser,   // action[1:0], list_choice[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // channel_index[5:0], zero fill[7:6]
  output logic [2:0]  out_tuser   // chosen[0], status[2:1]
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [RND_W-1:0]       rnd_r, rnd_nxt;
  logic                   anti_r, anti_nxt;
  logic [CNT_W-1:0]       walk_idx_r, walk_idx_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic                   res_chosen_r, res_chosen_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic                   out_chosen_r, out_chosen_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   accept;
  action_t                in_act;
  logic [1:0]             in_lc;
  logic [WEIGHT_BITS-1:0] in_weight;
  logic [RND_W-1:0]       in_rnd;
  logic                   full;
  logic                   sel_part, sel_anti, sel_single;
  logic                   out_free;
  logic                   walk_hit, walk_miss;

  logic                   ram_we;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  lst_cmd_t               lcmd;
  lst_stat_t              lstat;
  wop_t                   wop;
  logic                   hit;

  assign in_act     = action_t'(in_tuser[1:0]);
  assign in_lc      = in_tuser[3:2];
  assign in_weight  = in_tdata[WEIGHT_BITS-1:0];
  assign in_rnd     = in_tdata[63:32];
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign full       = (cnt_r >= CNT_W'(MAX_CHANNELS));
  assign sel_part   = lstat.fixed_mode && (in_lc == LC_PARTICLE) && lstat.p_nonempty;
  assign sel_anti   = lstat.fixed_mode && (in_lc == LC_ANTIPARTICLE) && lstat.a_nonempty;
  assign sel_single = (cnt_r == CNT_W'(1));
  assign out_free   = !out_valid_r || out_tready;
  assign walk_hit   = rd_pend_r && rd_vld_r && hit;
  assign walk_miss  = rd_pend_r && !rd_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_act == ACT_SELECT) begin
            if (sel_part || sel_anti) begin
              state_nxt = S_LIST_OUT;
            end else if (sel_single) begin
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_MUL_LO;
            end
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_LIST_OUT: state_nxt = S_OUT;
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_WALK;
      S_WALK: begin
        if (walk_hit || walk_miss) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    rnd_nxt        = rnd_r;
    anti_nxt       = anti_r;
    walk_idx_nxt   = walk_idx_r;
    rd_pend_nxt    = 1'b0;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    res_idx_nxt    = res_idx_r;
    res_chosen_nxt = res_chosen_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_idx_nxt    = out_idx_r;
    out_chosen_nxt = out_chosen_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_wdata      = in_weight;
    lcmd           = '{add: 1'b0, rd: 1'b0, adv: 1'b0, rewind: 1'b0,
                       anti: anti_r, idx: cnt_r[IDX_W-1:0]};
    wop            = WOP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_idx_nxt    = '0;
          res_chosen_nxt = 1'b0;
          res_status_nxt = ST_OK;
          unique case (in_act)
            ACT_ADD_WEIGHTED, ACT_ADD_FIXED: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                cnt_nxt        = cnt_r + CNT_W'(1);
                res_idx_nxt    = cnt_r[IDX_W-1:0];
                res_chosen_nxt = 1'b1;
                if (in_act == ACT_ADD_WEIGHTED) begin
                  total_nxt = total_r + TOT_W'(in_weight);
                end else begin
                  ram_wdata = '0;
                  lcmd.add  = 1'b1;
                  lcmd.anti = (in_lc == LC_ANTIPARTICLE);
                end
              end
            end
            ACT_REWIND: lcmd.rewind = 1'b1;
            ACT_SELECT: begin
              rnd_nxt = in_rnd;
              if (sel_part || sel_anti) begin
                lcmd.rd   = 1'b1;
                lcmd.anti = !sel_part;
                anti_nxt  = !sel_part;
              end else if (sel_single) begin
                res_chosen_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST_OUT: begin
        lcmd.adv       = 1'b1;
        res_idx_nxt    = lstat.rd_idx;
        res_chosen_nxt = 1'b1;
        res_status_nxt = ST_OK;
      end
      S_MUL_LO: wop = WOP_MUL_LO;
      S_MUL_HI: begin
        wop          = WOP_MUL_HI;
        walk_idx_nxt = '0;
      end
      S_WALK: begin
        // issue one weight read per cycle, compare the one read last cycle
        rd_pend_nxt  = 1'b1;
        rd_vld_nxt   = (walk_idx_r < cnt_r);
        rd_idx_nxt   = walk_idx_r[IDX_W-1:0];
        walk_idx_nxt = walk_idx_r + CNT_W'(1);
        if (rd_pend_r && rd_vld_r) begin
          wop = WOP_ACC;
        end
        if (walk_hit) begin
          res_idx_nxt    = rd_idx_r;
          res_chosen_nxt = 1'b1;
          res_status_nxt = ST_OK;
        end else if (walk_miss) begin
          res_idx_nxt    = '0;
          res_chosen_nxt = 1'b0;
          res_status_nxt = ST_NONE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = res_idx_r;
          out_chosen_nxt = res_chosen_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r        <= rnd_nxt;
    anti_r       <= anti_nxt;
    walk_idx_r   <= walk_idx_nxt;
    rd_vld_r     <= rd_vld_nxt;
    rd_idx_r     <= rd_idx_nxt;
    res_idx_r    <= res_idx_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_status_r <= res_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_status_r <= out_status_nxt;
  end

  wcs_weight_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (walk_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  wcs_lists u_lists (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (lcmd),
    .stat  (lstat)
  );

  wcs_walker u_walker (
    .clk   (clk),
    .op    (wop),
    .total (total_r),
    .rnd   (rnd_r),
    .wdata (ram_rdata),
    .hit   (hit)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, OUT_IDX_W'(out_idx_r)};
  assign out_tuser  = {out_status_r, out_chosen_r};

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_CHANNELS))
    else $error("channel count beyond table size");

  a_full_not_chosen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> !out_chosen_r)
    else $error("failed result marked as chosen");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second item taken while one is in work");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && rd_pend_r && rd_vld_r |-> (CNT_W'(rd_idx_r) < cnt_r))
    else $error("weight walk past the last channel");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import wcs_pkg::*;

  localparam int PROD_W = TOT_W + RND_W;
  localparam logic [1:0] LC_NONE  = 2'd0;
  localparam logic [1:0] LC_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    action_t     action;
    logic [31:0] weight;
    logic [1:0]  list_choice;
    logic [31:0] rnd;
  } channel_cmd_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] channel_index;
    logic                 chosen;
    status_t              status;
  } selection_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // weight[31:0], random_fraction[63:32]
  logic [3:0]  in_tuser = '0;   // action[1:0], list_choice[3:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // channel_index[5:0], zero fill[7:6]
  logic [2:0]  out_tuser;       // chosen[0], status[2:1]

  weighted_channel_selector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted block state
  logic [WEIGHT_BITS-1:0] weight_table [MAX_CHANNELS];
  logic [IDX_W-1:0]       part_list [MAX_CHANNELS];
  logic [IDX_W-1:0]       anti_list [MAX_CHANNELS];
  logic [TOT_W-1:0]       weight_sum = '0;
  int                     chan_count = 0;
  int                     part_count = 0;
  int                     anti_count = 0;
  int                     part_cursor = 0;
  int                     anti_cursor = 0;
  bit                     fixed_on = 1'b0;

  channel_cmd_t pending_cmds [$];
  selection_t   expected_selections [$];
  int           error_count = 0;

  function automatic selection_t predict_selection(channel_cmd_t cmd);
    selection_t        res;
    logic [PROD_W-1:0] thr;
    logic [TOT_W:0]    cum;
    int                pos;
    bit                found;
    res.channel_index = '0;
    res.chosen = 1'b0;
    res.status = ST_OK;
    case (cmd.action)
      ACT_ADD_WEIGHTED, ACT_ADD_FIXED: begin
        if (chan_count >= MAX_CHANNELS) begin
          res.status = ST_FULL;
        end else begin
          if (cmd.action == ACT_ADD_WEIGHTED) begin
            weight_table[chan_count] = cmd.weight[WEIGHT_BITS-1:0];
            weight_sum = weight_sum + TOT_W'(cmd.weight[WEIGHT_BITS-1:0]);
          end else begin
            weight_table[chan_count] = '0;
            if (cmd.list_choice == LC_ANTIPARTICLE) begin
              anti_list[anti_count] = IDX_W'(chan_count);
              anti_count++;
            end else begin
              part_list[part_count] = IDX_W'(chan_count);
              part_count++;
            end
            fixed_on = 1'b1;
          end
          res.channel_index = OUT_IDX_W'(chan_count);
          res.chosen = 1'b1;
          chan_count++;
        end
      end
      ACT_REWIND: begin
        part_cursor = 0;
        anti_cursor = 0;
      end
      default: begin
        if (fixed_on && cmd.list_choice == LC_PARTICLE && part_count != 0) begin
          pos = (part_cursor >= part_count) ? 0 : part_cursor;
          res.channel_index = OUT_IDX_W'(part_list[pos]);
          res.chosen = 1'b1;
          part_cursor = (pos + 1 >= part_count) ? 0 : pos + 1;
        end else if (fixed_on && cmd.list_choice == LC_ANTIPARTICLE && anti_count != 0) begin
          pos = (anti_cursor >= anti_count) ? 0 : anti_cursor;
          res.channel_index = OUT_IDX_W'(anti_list[pos]);
          res.chosen = 1'b1;
          anti_cursor = (pos + 1 >= anti_count) ? 0 : pos + 1;
        end else if (chan_count == 1) begin
          res.chosen = 1'b1;
        end else begin
          // roulette wheel: first cumulative weight above total * fraction
          thr = (PROD_W'(weight_sum) * PROD_W'(cmd.rnd)) >> 32;
          cum = '0;
          found = 1'b0;
          res.status = ST_NONE;
          for (int i = 0; i < chan_count && !found; i++) begin
            cum = cum + (TOT_W + 1)'(weight_table[i]);
            if (PROD_W'(cum) > thr) begin
              res.channel_index = OUT_IDX_W'(i);
              res.chosen = 1'b1;
              res.status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  // sender: bursts of items with random gaps
  logic in_accepted = 1'b0;
  logic next_valid;
  int   burst_left = 4;
  int   gap_left = 0;
  channel_cmd_t drive_cmd;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_accepted) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (pending_cmds.size() > 0) begin
        drive_cmd = pending_cmds.pop_front();
        in_tdata <= {drive_cmd.rnd, drive_cmd.weight};
        in_tuser <= {drive_cmd.list_choice, drive_cmd.action};
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        next_valid = 1'b0;
      end
      in_tvalid <= next_valid;
    end
  end

  // receiver: quiet stretches alternate with random stalls
  int stall_left = 0;
  int rx_phase = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_phase++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ((rx_phase / 256) % 4 != 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 19);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  channel_cmd_t seen_cmd;
  selection_t   got, want;

  always @(posedge clk) begin
    in_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      seen_cmd.action = action_t'(in_tuser[1:0]);
      seen_cmd.list_choice = in_tuser[3:2];
      seen_cmd.weight = in_tdata[31:0];
      seen_cmd.rnd = in_tdata[63:32];
      expected_selections = {expected_selections, predict_selection(seen_cmd)};
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.channel_index = out_tdata[OUT_IDX_W-1:0];
      got.chosen = out_tuser[0];
      got.status = status_t'(out_tuser[2:1]);
      if (expected_selections.size() == 0) begin
        $display("%0t: result item with none expected: index %0d chosen %0d status %0d",
                 $time, got.channel_index, got.chosen, got.status);
        error_count++;
      end else begin
        want = expected_selections.pop_front();
        if (got.channel_index !== want.channel_index || got.chosen !== want.chosen ||
            got.status !== want.status) begin
          $display({"%0t: expected index %0d chosen %0d status %0d,",
                    " actual index %0d chosen %0d status %0d"},
                   $time, want.channel_index, want.chosen, want.status,
                   got.channel_index, got.chosen, got.status);
          error_count++;
        end
      end
    end
  end

  task automatic queue_cmd(action_t act, logic [31:0] w, logic [1:0] lc, logic [31:0] r);
    channel_cmd_t c;
    c.action = act;
    c.weight = w;
    c.list_choice = lc;
    c.rnd = r;
    pending_cmds = {pending_cmds, c};
  endtask

  initial begin : stimulus
    action_t     act;
    logic [31:0] w, r;
    logic [1:0]  lc;
    int          pick;

    // empty table, lone channel, all-zero weights
    queue_cmd(ACT_SELECT, $urandom, LC_NONE, 32'hFFFF_FFFF);
    queue_cmd(ACT_REWIND, $urandom, LC_SPARE, $urandom);
    queue_cmd(ACT_ADD_WEIGHTED, 32'h0, LC_NONE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_NONE, 32'hFFFF_FFFF);
    queue_cmd(ACT_ADD_WEIGHTED, 32'h0, LC_SPARE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_NONE, 32'h0);
    // named list while fixed mode is still off
    queue_cmd(ACT_SELECT, $urandom, LC_PARTICLE, 32'h8000_0000);
    queue_cmd(ACT_ADD_WEIGHTED, 32'hFFFF_FFFF, LC_NONE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_NONE, 32'h0);
    queue_cmd(ACT_SELECT, $urandom, LC_NONE, 32'hFFFF_FFFF);
    // fixed channels on both lists, every list_choice
    queue_cmd(ACT_ADD_FIXED, $urandom, LC_PARTICLE, $urandom);
    queue_cmd(ACT_ADD_FIXED, $urandom, LC_ANTIPARTICLE, $urandom);
    queue_cmd(ACT_ADD_FIXED, $urandom, LC_NONE, $urandom);
    queue_cmd(ACT_ADD_FIXED, $urandom, LC_SPARE, $urandom);
    // particle list wraps after three entries
    for (int i = 0; i < 4; i++) queue_cmd(ACT_SELECT, $urandom, LC_PARTICLE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_ANTIPARTICLE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_ANTIPARTICLE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_PARTICLE, $urandom);
    queue_cmd(ACT_REWIND, $urandom, LC_NONE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_PARTICLE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_SPARE, 32'hFFFF_FFFF);
    queue_cmd(ACT_ADD_WEIGHTED, 32'hFFFF_FFFF, LC_NONE, $urandom);
    queue_cmd(ACT_SELECT, $urandom, LC_NONE, 32'hFFFF_FFFF);

    // random mix; the table fills up and later adds hit the full case
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) act = ACT_ADD_WEIGHTED;
      else if (pick < 30) act = ACT_ADD_FIXED;
      else if (pick < 36) act = ACT_REWIND;
      else act = ACT_SELECT;
      case ($urandom_range(0, 7))
        0: w = 32'h0;
        1: w = 32'hFFFF_FFFF;
        2: w = $urandom_range(0, 255);
        default: w = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: r = 32'h0;
        1: r = 32'hFFFF_FFFF;
        default: r = $urandom;
      endcase
      lc = ($urandom_range(0, 9) == 0) ? LC_SPARE : 2'($urandom_range(0, 2));
      queue_cmd(act, w, lc, r);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_tvalid || expected_selections.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: weighted_channel_selector.f
hdl/wcs_pkg.sv
hdl/wcs_weight_ram.sv
hdl/wcs_lists.sv
hdl/wcs_walker.sv
hdl/weighted_channel_selector.sv
verif/tb_top.sv
